/* design/ptw_pkg.sv */
// Package for the page table walker: shared types, result codes and PTE layout.
// No dependencies; used by every module of the walker and by its checker.
`default_nettype none

package ptw_pkg;

    localparam int VA_W       = 39;
    localparam int PA_W       = 56;
    localparam int PPN_W      = 44;
    localparam int PTE_W      = 64;
    localparam int LVL_W      = 2;
    localparam int PAGE_SHIFT = 12;
    localparam int PTE_SHIFT  = 3;   // 8-byte PTEs
    localparam int SH_W       = 6;   // holds any level shift up to 12 + 3*10

    // PTE bit positions
    localparam int PTE_V      = 0;
    localparam int PTE_R      = 1;
    localparam int PTE_X      = 3;
    localparam int PTE_PPN_LO = 10;
    localparam int PTE_PPN_HI = PTE_PPN_LO + PPN_W - 1;

    localparam int IN_DATA_W  = 104;  // vaddr + pte_word, padded to bytes
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2
    } t_kind;

    typedef enum logic {
        ACT_REQUEST  = 1'b0,
        ACT_RESPONSE = 1'b1
    } t_action;

    // One walk step: what to emit and how the walk state moves.
    typedef struct packed {
        logic              emit;
        t_kind             kind;
        logic [PA_W-1:0]   address;
        logic              nxt_active;
        logic [LVL_W-1:0]  nxt_level;
        logic              load_vaddr;
    } t_step;

endpackage

`default_nettype wire

/* design/page_table_translation_walker.sv */
// Page table walker top level: config register, walk state, result register.
// Instantiates ptw_in_reg and ptw_step; uses ptw_pkg.
//
// Usage:
//  - Config: write the root table PPN on i_cfg_data with i_cfg_valid; o_cfg_ready
//    is always high. Zero means no table: every request faults. Write only idle.
//  - Input stream (s_axis): tuser = action (0 translate request, 1 PTE response);
//    tdata = vaddr in [38:0], pte_word in [102:39]. A request restarts any walk;
//    a response while idle is dropped without a result.
//  - Output stream (m_axis): tuser = kind (read PTE, done, fault); tdata = PTE
//    address to read or the translated physical address, zero on a fault.
//    The master must answer each read with one response beat.
//  - Throughput: one beat per cycle while the result side does not stall. Path:
//    the input register, then one walk-step decode and add into the result
//    register.
//  - Stall: while m_axis_tready is low the result holds, the input register
//    still drains beats that give no result, and s_axis_tready drops once the
//    input register holds a beat that must wait for the result register.
//  - Reset (i_rst_n low, synchronous): walker idle, level and saved vaddr zero,
//    root PPN zero, both streams empty.
`default_nettype none

module page_table_translation_walker #(
    parameter int LEVELS     = 3,
    parameter int INDEX_BITS = 9
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // config write
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [ptw_pkg::PPN_W-1:0]       i_cfg_data,     // root_table_ppn
    // input stream
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire [ptw_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // vaddr, pte_word, pad
    input  wire [0:0]                      s_axis_tuser,   // action
    // result stream
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [ptw_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // address
    output logic [1:0]                     m_axis_tuser    // kind
);

    // root table register
    logic [ptw_pkg::PPN_W-1:0]  r_root_ppn;

    // walk state
    logic                       r_active;
    logic [ptw_pkg::LVL_W-1:0]  r_level;
    logic [ptw_pkg::VA_W-1:0]   r_saved_vaddr;

    // result register
    logic                       r_out_valid;
    ptw_pkg::t_kind             r_out_kind;
    logic [ptw_pkg::PA_W-1:0]   r_out_addr;

    logic                       in_valid;
    logic                       in_action;
    logic [ptw_pkg::VA_W-1:0]   in_vaddr;
    logic [ptw_pkg::PTE_W-1:0]  in_pte;
    logic                       advance;
    ptw_pkg::t_step             step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_ppn <= '0;
        end else if (i_cfg_valid) begin
            r_root_ppn <= i_cfg_data;
        end
    end

    ptw_in_reg u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_user   (s_axis_tuser[0]),
        .i_take   (advance),
        .o_valid  (in_valid),
        .o_action (in_action),
        .o_vaddr  (in_vaddr),
        .o_pte    (in_pte)
    );

    ptw_step #(
        .LEVELS     (LEVELS),
        .INDEX_BITS (INDEX_BITS)
    ) u_step (
        .i_action      (in_action),
        .i_vaddr       (in_vaddr),
        .i_pte         (in_pte),
        .i_root_ppn    (r_root_ppn),
        .i_active      (r_active),
        .i_level       (r_level),
        .i_saved_vaddr (r_saved_vaddr),
        .o_step        (step)
    );

    // a beat leaves the input register when its result (if any) has a slot
    assign advance = in_valid && (!step.emit || !r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_level       <= '0;
            r_saved_vaddr <= '0;
        end else if (advance) begin
            r_active <= step.nxt_active;
            r_level  <= step.nxt_level;
            if (step.load_vaddr) begin
                r_saved_vaddr <= in_vaddr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step.emit) begin
            r_out_kind <= step.kind;
            r_out_addr <= step.address;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_kind;

endmodule

`default_nettype wire

/* design/ptw_in_reg.sv */
// Input register stage of the page table walker.
// Holds one accepted beat until the step logic consumes it; uses ptw_pkg.
`default_nettype none

module ptw_in_reg (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire [ptw_pkg::IN_DATA_W-1:0]  i_data,
    input  wire                           i_user,
    input  wire                           i_take,
    output logic                          o_valid,
    output logic                          o_action,
    output logic [ptw_pkg::VA_W-1:0]      o_vaddr,
    output logic [ptw_pkg::PTE_W-1:0]     o_pte
);

    logic                       r_valid;
    logic                       r_action;
    logic [ptw_pkg::VA_W-1:0]   r_vaddr;
    logic [ptw_pkg::PTE_W-1:0]  r_pte;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_action <= i_user;
            r_vaddr  <= i_data[ptw_pkg::VA_W-1:0];
            r_pte    <= i_data[ptw_pkg::VA_W +: ptw_pkg::PTE_W];
        end
    end

    assign o_valid  = r_valid;
    assign o_action = r_action;
    assign o_vaddr  = r_vaddr;
    assign o_pte    = r_pte;

endmodule

`default_nettype wire

/* design/ptw_step.sv */
// Combinational walk step: decodes a request or a PTE response against walk state.
// Uses ptw_pkg; instantiated by the walker top level.
`default_nettype none

module ptw_step #(
    parameter int LEVELS     = 3,
    parameter int INDEX_BITS = 9
) (
    input  wire                           i_action,
    input  wire [ptw_pkg::VA_W-1:0]       i_vaddr,
    input  wire [ptw_pkg::PTE_W-1:0]      i_pte,
    input  wire [ptw_pkg::PPN_W-1:0]      i_root_ppn,
    input  wire                           i_active,
    input  wire [ptw_pkg::LVL_W-1:0]      i_level,
    input  wire [ptw_pkg::VA_W-1:0]       i_saved_vaddr,
    output ptw_pkg::t_step                o_step
);

    localparam logic [ptw_pkg::LVL_W-1:0] TopLevel = ptw_pkg::LVL_W'(LEVELS - 1);

    logic                               is_req;
    logic [ptw_pkg::LVL_W-1:0]          idx_level;
    logic [ptw_pkg::VA_W-1:0]           idx_va;
    logic [ptw_pkg::SH_W-1:0]           idx_sh;
    logic [ptw_pkg::SH_W-1:0]           leaf_sh;
    logic [ptw_pkg::VA_W-1:0]           va_shifted;
    logic [INDEX_BITS-1:0]              idx;
    logic [ptw_pkg::PA_W-1:0]           table_base;
    logic [ptw_pkg::PA_W-1:0]           pte_base;
    logic [ptw_pkg::PA_W-1:0]           pte_addr;
    logic [ptw_pkg::PA_W-1:0]           leaf_mask;
    logic [ptw_pkg::PA_W-1:0]           leaf_addr;
    logic                               pte_v;
    logic                               pte_leaf;

    assign is_req   = (i_action == ptw_pkg::ACT_REQUEST);
    assign pte_v    = i_pte[ptw_pkg::PTE_V];
    assign pte_leaf = |i_pte[ptw_pkg::PTE_X:ptw_pkg::PTE_R];
    assign pte_base = {i_pte[ptw_pkg::PTE_PPN_HI:ptw_pkg::PTE_PPN_LO],
                       ptw_pkg::PAGE_SHIFT'(0)};

    // index of next PTE: top level on a request, one level down on a response
    assign idx_level  = is_req ? TopLevel : (i_level - ptw_pkg::LVL_W'(1));
    assign idx_va     = is_req ? i_vaddr : i_saved_vaddr;
    assign idx_sh     = ptw_pkg::SH_W'(ptw_pkg::PAGE_SHIFT)
                      + ptw_pkg::SH_W'(idx_level) * ptw_pkg::SH_W'(INDEX_BITS);
    assign va_shifted = idx_va >> idx_sh;
    assign idx        = va_shifted[INDEX_BITS-1:0];
    assign table_base = is_req ? {i_root_ppn, ptw_pkg::PAGE_SHIFT'(0)} : pte_base;
    assign pte_addr   = table_base + (ptw_pkg::PA_W'(idx) << ptw_pkg::PTE_SHIFT);

    // leaf: page offset covers all levels below the current one
    assign leaf_sh    = ptw_pkg::SH_W'(ptw_pkg::PAGE_SHIFT)
                      + ptw_pkg::SH_W'(i_level) * ptw_pkg::SH_W'(INDEX_BITS);
    assign leaf_mask  = ~({ptw_pkg::PA_W{1'b1}} << leaf_sh);
    assign leaf_addr  = pte_base + (ptw_pkg::PA_W'(i_saved_vaddr) & leaf_mask);

    always_comb begin
        o_step            = '0;
        o_step.kind       = ptw_pkg::KIND_FAULT;
        o_step.nxt_active = i_active;
        o_step.nxt_level  = i_level;
        priority if (is_req) begin
            o_step.emit       = 1'b1;
            o_step.load_vaddr = 1'b1;
            o_step.nxt_level  = TopLevel;
            if (i_root_ppn == '0) begin
                o_step.nxt_active = 1'b0;
            end else begin
                o_step.kind       = ptw_pkg::KIND_READ;
                o_step.address    = pte_addr;
                o_step.nxt_active = 1'b1;
            end
        end else if (!i_active) begin
            o_step.emit = 1'b0;   // stray response
        end else if (!pte_v) begin
            o_step.emit       = 1'b1;
            o_step.nxt_active = 1'b0;
        end else if (pte_leaf) begin
            o_step.emit       = 1'b1;
            o_step.kind       = ptw_pkg::KIND_DONE;
            o_step.address    = leaf_addr;
            o_step.nxt_active = 1'b0;
        end else if (i_level == '0 || pte_base == '0) begin
            o_step.emit       = 1'b1;
            o_step.nxt_active = 1'b0;
        end else begin
            o_step.emit      = 1'b1;
            o_step.kind      = ptw_pkg::KIND_READ;
            o_step.address   = pte_addr;
            o_step.nxt_level = i_level - ptw_pkg::LVL_W'(1);
        end
    end

endmodule

`default_nettype wire

/* design/ptw_chk.sv */
// Port-level checker for the page table walker, bound to the top level.
// Uses ptw_pkg for result codes; sees only the top level's ports.
`default_nettype none

module ptw_chk (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            s_axis_tvalid,
    input wire                            s_axis_tready,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [ptw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input wire [1:0]                      m_axis_tuser
);

    // held result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // a fault never carries an address
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ptw_pkg::KIND_FAULT |-> m_axis_tdata == '0)
        else $error("fault result with nonzero address");

    // reset empties the result stream
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // with the result side free, input is never back-pressured
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && $past(!m_axis_tvalid) && $past(i_rst_n) |-> s_axis_tready)
        else $error("input stalled while result side idle");

endmodule

bind page_table_translation_walker ptw_chk u_ptw_chk (.*);

`default_nettype wire
